[hw/rtl/cursor_line_edit_buffer_core_defines.svh]
// Assertion macros shared by the line edit buffer RTL.
`ifndef CURSOR_LINE_EDIT_BUFFER_CORE_DEFINES_SVH
`define CURSOR_LINE_EDIT_BUFFER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every i_clk edge out of reset.
`define CLB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every i_clk edge out of reset.
`define CLB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/clb_pkg.sv]
// Package: sizes, operation and status codes, and the result record.
package clb_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int POS_W    = 7;
    localparam int FUNC_W   = 3;
    localparam int CHAR_W   = 8;
    localparam int STAT_W   = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT    = 3'd0,
        FN_DEL_LEFT  = 3'd1,
        FN_DEL_RIGHT = 3'd2,
        FN_LEFT      = 3'd3,
        FN_RIGHT     = 3'd4,
        FN_SET       = 3'd5,
        FN_READ      = 3'd6
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_EDGE = 2'd2
    } t_status;

    typedef struct packed {
        t_status           status;
        logic [POS_W-1:0]  cursor_pos;
        logic [POS_W-1:0]  length;
        logic [CHAR_W-1:0] char_out;
        logic              left_of_cursor;
    } t_rsp;

endpackage

[hw/rtl/clb_if.sv]
// Request and response channel interfaces of the line edit buffer.
interface clb_req_if;
    import clb_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] char_in;
    logic [POS_W-1:0]  position;

    modport source (output valid, func, char_in, position, input ready);
    modport sink   (input valid, func, char_in, position, output ready);
endinterface

interface clb_rsp_if;
    import clb_pkg::*;

    logic              valid;
    logic              ready;
    t_status           status;
    logic [POS_W-1:0]  cursor_pos;
    logic [POS_W-1:0]  length;
    logic [CHAR_W-1:0] char_out;
    logic              left_of_cursor;

    modport source (output valid, status, cursor_pos, length, char_out, left_of_cursor,
                    input ready);
    modport sink   (input valid, status, cursor_pos, length, char_out, left_of_cursor,
                    output ready);
endinterface

[hw/rtl/clb_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered data.
module clb_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/cursor_line_edit_buffer_core.sv]
// Line edit buffer top level: cursor/length control, shift sequencer, result register.
// One editable line of up to CAPACITY bytes with a cursor, held in a one-port-write,
// one-port-read RAM. Items are taken one at a time. Cursor moves, set and refused
// operations pass through r_res into the result register; a read also waits in
// S_RDWAIT for the RAM data. Insert and delete move the tail one byte per cycle
// through the RAM (read one entry, write it back one place over in the next cycle),
// and insert then drops in the new byte from S_WRCH. The result register frees the
// input while a result waits to be taken; a new result that finds it still occupied
// holds the input off until it drains.
`include "cursor_line_edit_buffer_core_defines.svh"

module cursor_line_edit_buffer_core
    import clb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    clb_req_if.sink    i_req,
    clb_rsp_if.source  o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_WRCH,
        S_DEL,
        S_RDWAIT,
        S_HOLD
    } t_state;

    t_state            r_state,  n_state;
    logic [POS_W-1:0]  r_cursor, n_cursor;
    logic [POS_W-1:0]  r_fill,   n_fill;
    logic [ADDR_W-1:0] r_idx,    n_idx;
    logic [ADDR_W-1:0] r_lim,    n_lim;
    logic [CHAR_W-1:0] r_ch,     n_ch;
    t_rsp              r_res,    n_res;
    t_rsp              r_out,    n_out;
    logic              r_out_valid, n_out_valid;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CHAR_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CHAR_W-1:0] ram_rdata;

    logic              accept;
    logic              out_free;
    logic [POS_W-1:0]  fill_m1;
    logic [POS_W-1:0]  cur_m1;
    logic [POS_W-1:0]  cur_p1;

    clb_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (CHAR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign fill_m1     = r_fill - POS_W'(1);
    assign cur_m1      = r_cursor - POS_W'(1);
    assign cur_p1      = r_cursor + POS_W'(1);

    always_comb begin
        n_state     = r_state;
        n_cursor    = r_cursor;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_lim       = r_lim;
        n_ch        = r_ch;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_waddr   = r_idx + ADDR_W'(1);
        ram_wdata   = ram_rdata;
        ram_raddr   = r_idx;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_HOLD;
                    n_ch    = i_req.char_in;
                    n_res   = '{status: ST_DONE, cursor_pos: r_cursor, length: r_fill,
                                char_out: '0, left_of_cursor: 1'b0};
                    unique case (t_func'(i_req.func))
                        FN_INSERT: begin
                            if (r_fill >= POS_W'(CAPACITY)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                n_cursor         = cur_p1;
                                n_fill           = r_fill + POS_W'(1);
                                n_res.cursor_pos = cur_p1;
                                n_res.length     = r_fill + POS_W'(1);
                                n_lim            = r_cursor[ADDR_W-1:0];
                                if (r_fill > r_cursor) begin
                                    ram_raddr = fill_m1[ADDR_W-1:0];
                                    n_idx     = fill_m1[ADDR_W-1:0];
                                    n_state   = S_INS;
                                end else begin
                                    ram_we    = 1'b1;
                                    ram_waddr = r_cursor[ADDR_W-1:0];
                                    ram_wdata = i_req.char_in;
                                end
                            end
                        end
                        FN_DEL_LEFT: begin
                            if (r_cursor == '0) begin
                                n_res.status = ST_EDGE;
                            end else begin
                                n_cursor         = cur_m1;
                                n_fill           = fill_m1;
                                n_res.cursor_pos = cur_m1;
                                n_res.length     = fill_m1;
                                if (r_cursor < r_fill) begin
                                    ram_raddr = r_cursor[ADDR_W-1:0];
                                    n_idx     = r_cursor[ADDR_W-1:0];
                                    n_lim     = fill_m1[ADDR_W-1:0];
                                    n_state   = S_DEL;
                                end
                            end
                        end
                        FN_DEL_RIGHT: begin
                            if (r_cursor >= r_fill) begin
                                n_res.status = ST_EDGE;
                            end else begin
                                n_fill       = fill_m1;
                                n_res.length = fill_m1;
                                if (cur_p1 < r_fill) begin
                                    ram_raddr = cur_p1[ADDR_W-1:0];
                                    n_idx     = cur_p1[ADDR_W-1:0];
                                    n_lim     = fill_m1[ADDR_W-1:0];
                                    n_state   = S_DEL;
                                end
                            end
                        end
                        FN_LEFT: begin
                            if (r_cursor == '0) begin
                                n_res.status = ST_EDGE;
                            end else begin
                                n_cursor         = cur_m1;
                                n_res.cursor_pos = cur_m1;
                            end
                        end
                        FN_RIGHT: begin
                            if (r_cursor >= r_fill) begin
                                n_res.status = ST_EDGE;
                            end else begin
                                n_cursor         = cur_p1;
                                n_res.cursor_pos = cur_p1;
                            end
                        end
                        FN_SET: begin
                            n_cursor = (i_req.position > r_fill) ? r_fill : i_req.position;
                            n_res.cursor_pos = n_cursor;
                        end
                        FN_READ: begin
                            if (i_req.position >= r_fill) begin
                                n_res.status = ST_EDGE;
                            end else begin
                                n_res.left_of_cursor = (i_req.position < r_cursor);
                                ram_raddr = i_req.position[ADDR_W-1:0];
                                n_state   = S_RDWAIT;
                            end
                        end
                        default: begin
                            n_res.status = ST_EDGE;
                        end
                    endcase
                end
            end
            S_INS: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx + ADDR_W'(1);
                ram_wdata = ram_rdata;
                if (r_idx == r_lim) begin
                    n_state = S_WRCH;
                end else begin
                    ram_raddr = r_idx - ADDR_W'(1);
                    n_idx     = r_idx - ADDR_W'(1);
                end
            end
            S_WRCH: begin
                ram_we    = 1'b1;
                ram_waddr = r_lim;
                ram_wdata = r_ch;
                n_state   = S_HOLD;
            end
            S_DEL: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx - ADDR_W'(1);
                ram_wdata = ram_rdata;
                if (r_idx == r_lim) begin
                    n_state = S_HOLD;
                end else begin
                    ram_raddr = r_idx + ADDR_W'(1);
                    n_idx     = r_idx + ADDR_W'(1);
                end
            end
            S_RDWAIT: begin
                n_res.char_out = ram_rdata;
                n_state        = S_HOLD;
            end
            S_HOLD: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cursor    <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
        r_idx <= n_idx;
        r_lim <= n_lim;
        r_ch  <= n_ch;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out.status;
    assign o_rsp.cursor_pos     = r_out.cursor_pos;
    assign o_rsp.length         = r_out.length;
    assign o_rsp.char_out       = r_out.char_out;
    assign o_rsp.left_of_cursor = r_out.left_of_cursor;

    `CLB_ASSERT_NOW(a_cursor_in_line, 1'b1, r_cursor <= r_fill, "cursor beyond length")
    `CLB_ASSERT_NOW(a_fill_in_range, 1'b1, r_fill <= POS_W'(CAPACITY), "length beyond capacity")
    `CLB_ASSERT_NEXT(a_insert_grows,
        accept && t_func'(i_req.func) == FN_INSERT && r_fill < POS_W'(CAPACITY),
        r_fill == $past(r_fill) + POS_W'(1), "insert did not grow the line")
    `CLB_ASSERT_NEXT(a_read_waits_ram,
        accept && t_func'(i_req.func) == FN_READ && i_req.position < r_fill,
        r_state == S_RDWAIT, "valid read skipped the RAM access")

endmodule
